[rtl/ple_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ---------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int OP_W   = 3;
  localparam int POS_W  = 8;
  localparam int DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_FIND   = 3'd3,
    OP_SIZE   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_INS_NODE,
    S_INS_LINK,
    S_DEL_HEAD,
    S_DEL_LINK,
    S_DONE
  } state_t;

endpackage : ple_pkg
`default_nettype wire

[rtl/ple_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ple_if
// Request and response channels of the positional list engine.
// ---------------------------------------------------------------------------
interface ple_req_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface : ple_req_if

interface ple_rsp_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] read_value;
  logic [POS_W-1:0]         found_position;
  logic [POS_W-1:0]         list_length;

  modport source (output valid, output ok, output read_value, output found_position,
                  output list_length, input ready);
  modport sink   (input valid, input ok, input read_value, input found_position,
                  input list_length, output ready);
endinterface : ple_rsp_if
`default_nettype wire

[rtl/positional_list_engine.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values in linked memory slots with a free-slot stack.
//
//   port  dir     beat carries
//   req   sink    op, position, value
//   rsp   source  ok, read_value, found_position, list_length
//
// The walk follows one link per cycle through the slot memories (one
// synchronous read port each).
// No clearing pass after reset: unused free-stack entries below the low-water
// mark read as their reset slot index.
// One request in flight; a new one is taken while the last response waits.
// ---------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEF
) (
  input  wire      clk,
  input  wire      rst,
  ple_req_if.sink  req,
  ple_rsp_if.source rsp
);
  import ple_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // slot memories and free stack
  logic [VALUE_BITS-1:0] slot_values [CAPACITY];
  logic [SW-1:0]         slot_links  [CAPACITY];
  logic [SW-1:0]         free_slots  [CAPACITY];

  state_t state, state_next;

  logic [SW-1:0]         head_slot;
  logic [CW-1:0]         element_count;
  logic [CW-1:0]         free_count;
  logic [CW-1:0]         low_water;

  logic [OP_W-1:0]       op_q;
  logic [POS_W-1:0]      pos_q;
  logic [POS_W-1:0]      walk_goal;
  logic [VALUE_BITS-1:0] target;
  logic [CW-1:0]         idx;
  logic [SW-1:0]         cur_slot;
  logic [SW-1:0]         prev_slot;
  logic [SW-1:0]         next_link;
  logic [SW-1:0]         del_slot;

  logic [SW-1:0]         link_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [SW-1:0]         stack_q;

  logic                  res_ok;
  logic [DATA_W-1:0]     res_rd;
  logic [POS_W-1:0]      res_found;

  // read address follows the chain: head on accept, then each fetched link
  logic [SW-1:0]         rd_addr;
  logic [CW-1:0]         fc_m1;
  logic [SW-1:0]         new_slot;
  logic                  accept;
  logic                  rd_pos_ok;
  logic                  ins_pos_ok;
  logic                  walk_hit;
  logic                  find_hit;
  logic                  out_free;

  logic                  lnk_we;
  logic [SW-1:0]         lnk_wa;
  logic [SW-1:0]         lnk_wd;
  logic                  val_we;
  logic                  stk_we;
  logic [SW-1:0]         stk_wd;
  logic                  commit_ins;
  logic                  commit_del;

  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign fc_m1     = free_count - CW'(1);
  assign rd_addr   = (state == S_IDLE) ? head_slot : link_q;
  // entries below the low-water mark were never pushed
  assign new_slot  = (fc_m1 >= low_water) ? stack_q : SW'(CW'(CAPACITY) - free_count);

  assign rd_pos_ok  = (req.position != '0) &&
                      ({1'b0, req.position} <= (POS_W+1)'(element_count));
  assign ins_pos_ok = (req.position != '0) &&
                      ({1'b0, req.position} <= (POS_W+1)'(element_count) + 1'b1) &&
                      (free_count != '0);

  assign walk_hit = (POS_W'(idx) == walk_goal);
  assign find_hit = (val_q == target);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    lnk_we     = 1'b0;
    lnk_wa     = prev_slot;
    lnk_wd     = link_q;
    val_we     = 1'b0;
    stk_we     = 1'b0;
    stk_wd     = del_slot;
    commit_ins = 1'b0;
    commit_del = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_DONE;
          case (req.op)
            OP_INSERT: begin
              if (ins_pos_ok) begin
                state_next = (req.position == POS_W'(1)) ? S_INS_NODE : S_WALK;
              end
            end
            OP_DELETE: begin
              if (rd_pos_ok) begin
                state_next = (req.position == POS_W'(1)) ? S_DEL_HEAD : S_WALK;
              end
            end
            OP_GET: begin
              if (rd_pos_ok) begin
                state_next = S_WALK;
              end
            end
            OP_FIND: begin
              if (element_count != '0) begin
                state_next = S_WALK;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        case (op_q)
          OP_INSERT: if (walk_hit) state_next = S_INS_NODE;
          OP_DELETE: if (walk_hit) state_next = S_DEL_LINK;
          OP_GET:    if (walk_hit) state_next = S_DONE;
          OP_FIND:   if (find_hit || idx == element_count) state_next = S_DONE;
          default:   state_next = S_DONE;
        endcase
      end
      S_INS_NODE: begin
        lnk_we = 1'b1;
        lnk_wa = new_slot;
        lnk_wd = (pos_q == POS_W'(1)) ? head_slot : next_link;
        val_we = 1'b1;
        if (pos_q == POS_W'(1)) begin
          commit_ins = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        lnk_we     = 1'b1;
        lnk_wa     = prev_slot;
        lnk_wd     = new_slot;
        commit_ins = 1'b1;
        state_next = S_DONE;
      end
      S_DEL_HEAD: begin
        stk_we     = 1'b1;
        stk_wd     = head_slot;
        commit_del = 1'b1;
        state_next = S_DONE;
      end
      S_DEL_LINK: begin
        // link_q now holds the link of the removed slot
        lnk_we     = 1'b1;
        lnk_wa     = prev_slot;
        lnk_wd     = link_q;
        stk_we     = 1'b1;
        stk_wd     = del_slot;
        commit_del = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // memories
  always_ff @(posedge clk) begin
    if (lnk_we) begin
      slot_links[lnk_wa] <= lnk_wd;
    end
    if (val_we) begin
      slot_values[new_slot] <= target;
    end
    if (stk_we) begin
      free_slots[free_count[SW-1:0]] <= stk_wd;
    end
    link_q  <= slot_links[rd_addr];
    val_q   <= slot_values[rd_addr];
    stack_q <= free_slots[fc_m1[SW-1:0]];
  end

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot     <= '0;
      element_count <= '0;
      free_count    <= CW'(CAPACITY);
      low_water     <= CW'(CAPACITY);
    end else begin
      if (commit_ins) begin
        element_count <= element_count + CW'(1);
        free_count    <= fc_m1;
        if (fc_m1 < low_water) begin
          low_water <= fc_m1;
        end
        if (pos_q == POS_W'(1)) begin
          head_slot <= new_slot;
        end
      end
      if (commit_del) begin
        element_count <= element_count - CW'(1);
        free_count    <= free_count + CW'(1);
        if (state == S_DEL_HEAD) begin
          head_slot <= link_q;
        end
      end
    end
  end

  // request context and walk datapath
  always_ff @(posedge clk) begin
    cur_slot <= rd_addr;
    if (accept) begin
      op_q      <= req.op;
      pos_q     <= req.position;
      walk_goal <= (req.op == OP_GET) ? req.position : req.position - POS_W'(1);
      target    <= VALUE_BITS'($signed(req.value));
      idx       <= CW'(1);
      res_ok    <= (req.op == OP_SIZE);
      res_rd    <= '0;
      res_found <= '0;
    end else if (state == S_WALK) begin
      idx <= idx + CW'(1);
      case (op_q)
        OP_INSERT: begin
          prev_slot <= cur_slot;
          next_link <= link_q;
        end
        OP_DELETE: begin
          prev_slot <= cur_slot;
          del_slot  <= link_q;
        end
        OP_GET: begin
          if (walk_hit) begin
            res_ok <= 1'b1;
            res_rd <= DATA_W'($signed(val_q));
          end
        end
        OP_FIND: begin
          if (find_hit) begin
            res_ok    <= 1'b1;
            res_found <= POS_W'(idx);
          end
        end
        default: res_ok <= 1'b0;
      endcase
    end else if (commit_ins || commit_del) begin
      res_ok <= 1'b1;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.ok             <= res_ok;
      rsp.read_value     <= res_rd;
      rsp.found_position <= res_found;
      rsp.list_length    <= POS_W'(element_count);
    end
  end

`ifndef SYNTHESIS
  a_slot_balance: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(element_count) + (CW+1)'(free_count) == (CW+1)'(CAPACITY))
    else $error("list length and free count do not add up to capacity");

  a_low_water: assert property (@(posedge clk) disable iff (rst)
    low_water <= free_count)
    else $error("free-stack low-water mark above free count");

  a_find_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found_position != '0) |-> rsp.ok)
    else $error("find position reported without ok");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (idx <= element_count))
    else $error("walk ran past the end of the list");
`endif

endmodule : positional_list_engine
`default_nettype wire

[tb/sv/positional_list_engine_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_list_engine_test
// Self-checking bench for the positional list engine. A queue-based model of
// the list predicts every response. Directed requests hit the edges first:
// empty list, bad positions, extreme values, unknown ops. Random traffic then
// swings the list between empty and full. Both channels stall in random
// bursts.
// ---------------------------------------------------------------------------
module positional_list_engine_test;
  import ple_pkg::*;

  localparam int LIST_CAPACITY = CAPACITY_DEF;
  localparam int RANDOM_ITEMS  = 1525;
  localparam int QUIET_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam logic [OP_W-1:0] OP_RSVD_LO = OP_W'(OP_SIZE + 1);
  localparam logic [OP_W-1:0] OP_RSVD_HI = {OP_W{1'b1}};

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] elements[$];
    list_result_t             awaiting[$];
    int errors;
    int requests;
    int checked;
    int rejected;
    int peak_length;

    function int length();
      return elements.size();
    endfunction

    function logic signed [DATA_W-1:0] element_at(int idx);
      return elements[idx];
    endfunction

    function int pending();
      return awaiting.size();
    endfunction

    // Apply one accepted request to the list and queue the response it causes.
    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_result_t r;
      int len;
      int p;
      len = elements.size();
      p = pos;
      r = '0;
      case (op)
        OP_INSERT: begin
          if (p >= 1 && p <= len + 1 && len < LIST_CAPACITY) begin
            elements.insert(p - 1, val);
            r.ok = 1'b1;
          end
        end
        OP_DELETE: begin
          if (p >= 1 && p <= len) begin
            elements.delete(p - 1);
            r.ok = 1'b1;
          end
        end
        OP_GET: begin
          if (p >= 1 && p <= len) begin
            r.read_value = elements[p - 1];
            r.ok = 1'b1;
          end
        end
        OP_FIND: begin
          for (int i = 0; i < len; i++) begin
            if (elements[i] == val) begin
              r.found_position = POS_W'(i + 1);
              r.ok = 1'b1;
              break;
            end
          end
        end
        OP_SIZE: r.ok = 1'b1;
        default: ;
      endcase
      r.list_length = POS_W'(elements.size());
      if (!r.ok) rejected++;
      if (elements.size() > peak_length) peak_length = elements.size();
      requests++;
      awaiting.push_back(r);
    endfunction

    function void check_response(logic ok, logic signed [DATA_W-1:0] read_value,
                                 logic [POS_W-1:0] found_position,
                                 logic [POS_W-1:0] list_length);
      list_result_t want;
      if (awaiting.size() == 0) begin
        $error("response beat with nothing outstanding");
        errors++;
        return;
      end
      want = awaiting.pop_front();
      checked++;
      if (ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, ok);
        errors++;
      end
      if (read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, read_value);
        errors++;
      end
      if (found_position !== want.found_position) begin
        $error("found_position: expected %0d, got %0d", want.found_position,
               found_position);
        errors++;
      end
      if (list_length !== want.list_length) begin
        $error("list_length: expected %0d, got %0d", want.list_length, list_length);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count = 0;
  bit   idle_on = 1'b1;
  int   gap_pct = 20;
  int   stall_pct = 20;

  list_scoreboard board = new();

  ple_req_if req_bus();
  ple_rsp_if rsp_bus();

  positional_list_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready)
      board.check_response(rsp_bus.ok, rsp_bus.read_value, rsp_bus.found_position,
                           rsp_bus.list_length);
  end

  // Response side back-pressure: random bursts of ready low.
  initial begin : rsp_ready_driver
    int gap;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && idle_on && $urandom_range(0, 99) < stall_pct) begin
        gap = $urandom_range(1, 15);
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
    end
  end

  task automatic push_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 15);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.op       <= op;
    req_bus.position <= pos;
    req_bus.value    <= val;
    do @(posedge clk); while (!req_bus.ready);
    board.note_request(op, pos, val);
  endtask

  task automatic random_request(input int insert_pct);
    int len;
    int roll;
    int hi;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic signed [DATA_W-1:0] val;
    len = board.length();
    if ($urandom_range(0, 99) < insert_pct) begin
      op = OP_INSERT;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 45) op = OP_DELETE;
      else if (roll < 65) op = OP_GET;
      else if (roll < 85) op = OP_FIND;
      else if (roll < 95) op = OP_SIZE;
      else op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    end

    hi = (op == OP_INSERT) ? len + 1 : ((len > 0) ? len : 1);
    roll = $urandom_range(0, 99);
    if (roll < 84) pos = POS_W'($urandom_range(1, hi));
    else if (roll < 89) pos = '0;
    else if (roll < 95) pos = POS_W'(hi + $urandom_range(1, 3));
    else pos = POS_W'($urandom());

    // small value pool keeps duplicates around so find has real work to do
    if (op == OP_FIND && len > 0 && $urandom_range(0, 99) < 65) begin
      val = board.element_at($urandom_range(0, len - 1));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        val = $urandom_range(0, 7);
        val = val - 4;
      end else if (roll < 50) begin
        case ($urandom_range(0, 3))
          0:       val = 32'sh8000_0000;
          1:       val = 32'sh7fff_ffff;
          2:       val = '0;
          default: val = '1;
        endcase
      end else begin
        val = $urandom();
      end
    end
    push_request(op, pos, val);
  endtask

  task automatic pick_idle();
    case ($urandom_range(0, 2))
      0:       gap_pct = 0;
      1:       gap_pct = 10;
      default: gap_pct = 35;
    endcase
    case ($urandom_range(0, 2))
      0:       stall_pct = 0;
      1:       stall_pct = 10;
      default: stall_pct = 35;
    endcase
  endtask

  initial begin : stimulus
    bit filling;
    int extra;
    req_bus.valid    <= 1'b0;
    req_bus.op       <= OP_SIZE;
    req_bus.position <= '0;
    req_bus.value    <= '0;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty list
    push_request(OP_SIZE,   8'd0,   32'sd0);
    push_request(OP_GET,    8'd1,   32'sd0);
    push_request(OP_DELETE, 8'd1,   32'sd0);
    push_request(OP_FIND,   8'd0,   32'sd0);
    push_request(OP_INSERT, 8'd0,   32'sd5);
    push_request(OP_INSERT, 8'd2,   32'sd5);
    // build [min, 0, max, -1]
    push_request(OP_INSERT, 8'd1,   32'sh7fff_ffff);
    push_request(OP_INSERT, 8'd1,   32'sh8000_0000);
    push_request(OP_INSERT, 8'd3,   -32'sd1);
    push_request(OP_INSERT, 8'd2,   32'sd0);
    push_request(OP_INSERT, 8'd255, 32'sd9);
    push_request(OP_GET,    8'd1,   32'sd0);
    push_request(OP_GET,    8'd4,   32'sd0);
    push_request(OP_GET,    8'd5,   32'sd0);
    push_request(OP_GET,    8'd0,   32'sd0);
    push_request(OP_FIND,   8'd0,   -32'sd1);
    push_request(OP_FIND,   8'd0,   32'sh7fff_ffff);
    push_request(OP_FIND,   8'd0,   32'sd12345);
    push_request(OP_DELETE, 8'd0,   32'sd0);
    push_request(OP_DELETE, 8'd255, 32'sd0);
    push_request(OP_DELETE, 8'd4,   32'sd0);
    push_request(OP_DELETE, 8'd1,   32'sd0);
    // duplicate value: find returns the first one
    push_request(OP_INSERT, 8'd1,   32'sd0);
    push_request(OP_FIND,   8'd255, 32'sd0);
    push_request(OP_RSVD_LO,               8'd255, -32'sd1);
    push_request(OP_W'(OP_RSVD_LO + 1'b1), 8'd1,   32'sd0);
    push_request(OP_RSVD_HI,               8'd255, -32'sd1);
    push_request(OP_SIZE,   8'd255, -32'sd1);

    // alternate between filling to capacity and draining to empty,
    // lingering at each extreme for a while
    filling = 1'b1;
    extra = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      random_request(filling ? 75 : 5);
      if (filling ? (board.length() == LIST_CAPACITY) : (board.length() == 0))
        extra++;
      if (extra >= 20) begin
        filling = !filling;
        extra = 0;
        pick_idle();
      end
    end
    req_bus.valid <= 1'b0;

    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d responses checked, %0d rejected by the block",
             board.requests, board.checked, board.rejected);
    $display("list length peaked at %0d of %0d slots", board.peak_length, LIST_CAPACITY);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : positional_list_engine_test

[files.f]
rtl/ple_pkg.sv
rtl/ple_if.sv
rtl/positional_list_engine.sv
tb/sv/positional_list_engine_test.sv
